// ===== sv/frame_rate_limiter_core_macros.svh =====
// Assertion macros shared by the frame rate limiter RTL.
// Included by modules that carry concurrent assertions; no other dependencies.
`ifndef FRAME_RATE_LIMITER_CORE_MACROS_SVH
`define FRAME_RATE_LIMITER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FRL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FRL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/frl_pkg.sv =====
// Package for the frame rate limiter: word types, register codes and helpers.
// No dependencies; imported by every module of the block.
`default_nettype none

package frl_pkg;

    localparam int unsigned TickWidth   = 32;
    localparam int unsigned BudgetWidth = 16;
    localparam int unsigned CfgIdxWidth = 8;
    localparam int unsigned CfgDatWidth = 32;

    typedef logic [TickWidth-1:0]   tick_t;
    typedef logic [BudgetWidth-1:0] budget_t;

    typedef enum logic [0:0] {
        CMD_POLL = 1'b0,
        CMD_WORK_DONE = 1'b1
    } cmd_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        REG_FRAME_PERIOD = 8'd0,
        REG_SLEEP_MARGIN = 8'd1,
        REG_WINDOW       = 8'd2,
        REG_BUDGET_LIMIT = 8'd3
    } cfg_reg_t;

    typedef struct packed {
        logic  command;
        tick_t elapsed_ticks;
    } in_word_t;

    typedef struct packed {
        logic  run_frame;
        logic  sleep_request;
        tick_t frame_ticks;
        logic  stats_valid;
        tick_t stats_frames;
        tick_t stats_ticks;
    } out_word_t;

    typedef struct packed {
        tick_t   frame_period_ticks;
        tick_t   sleep_margin_ticks;
        tick_t   window_ticks;
        budget_t sleep_budget_limit;
    } frl_cfg_t;

    localparam tick_t TickMax = '1;

    function automatic tick_t sat_add(input tick_t a, input tick_t b);
        logic [TickWidth:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[TickWidth] ? TickMax : sum[TickWidth-1:0];
    endfunction

    function automatic tick_t sat_sub(input tick_t a, input tick_t b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

`default_nettype wire

// ===== sv/frl_input_stage.sv =====
// Input register of the frame rate limiter: holds one accepted word.
// Depends on frl_pkg for the input word type.
`default_nettype none

module frl_input_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire frl_pkg::in_word_t in_word,
    input  wire logic             take,
    output logic                  held_valid,
    output frl_pkg::in_word_t     held_word
);
    import frl_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_word_t word_reg;
    logic     load;

    assign in_stall   = valid_reg && !take;
    assign load       = in_valid && !in_stall;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            word_reg <= in_word;
        end
    end

endmodule

`default_nettype wire

// ===== sv/frl_engine.sv =====
// Timing engine: accumulators, marks, frame count and sleep budget, with the
// per-word update logic. Depends on frl_pkg and the assertion macro header.
`default_nettype none
`include "frame_rate_limiter_core_macros.svh"

module frl_engine (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire frl_pkg::in_word_t  item,
    input  wire frl_pkg::frl_cfg_t  cfg,
    output frl_pkg::out_word_t     result
);
    import frl_pkg::*;

    tick_t   frame_accum_reg, frame_accum_next;
    tick_t   frame_mark_reg, frame_mark_next;
    tick_t   window_accum_reg, window_accum_next;
    tick_t   window_mark_reg, window_mark_next;
    tick_t   frames_in_window_reg, frames_in_window_next;
    budget_t sleep_budget_reg, sleep_budget_next;

    tick_t frame_sum;
    tick_t window_sum;
    logic  frame_due;
    logic  check_window;
    logic  window_closed;

    always_comb
    begin
        frame_sum  = sat_add(frame_accum_reg, item.elapsed_ticks);
        window_sum = sat_add(window_accum_reg, item.elapsed_ticks);
        frame_due  = (item.command == CMD_POLL) && (frame_sum >= cfg.frame_period_ticks);
        check_window  = !frame_due;
        window_closed = check_window && (window_sum >= cfg.window_ticks);

        result                = '0;
        frame_accum_next      = frame_sum;
        frame_mark_next       = frame_mark_reg;
        window_accum_next     = window_sum;
        window_mark_next      = window_mark_reg;
        frames_in_window_next = frames_in_window_reg;
        sleep_budget_next     = sleep_budget_reg;

        if (frame_due)
        begin
            result.run_frame   = 1'b1;
            result.frame_ticks = sat_sub(frame_sum, frame_mark_reg);
            frame_accum_next   = frame_sum - cfg.frame_period_ticks;
            frame_mark_next    = frame_sum - cfg.frame_period_ticks;
            if (frames_in_window_reg != TickMax)
            begin
                frames_in_window_next = frames_in_window_reg + 1'b1;
            end
            sleep_budget_next = cfg.sleep_budget_limit;
        end
        else if (item.command == CMD_POLL && sleep_budget_reg != '0
                 && (cfg.frame_period_ticks - frame_sum) > cfg.sleep_margin_ticks)
        begin
            result.sleep_request = 1'b1;
            sleep_budget_next    = sleep_budget_reg - 1'b1;
        end

        if (window_closed)
        begin
            result.stats_valid    = 1'b1;
            result.stats_frames   = frames_in_window_reg;
            result.stats_ticks    = sat_sub(window_sum, window_mark_reg);
            window_accum_next     = window_sum - cfg.window_ticks;
            window_mark_next      = window_sum - cfg.window_ticks;
            frames_in_window_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_accum_reg      <= '0;
            frame_mark_reg       <= '0;
            window_accum_reg     <= '0;
            window_mark_reg      <= '0;
            frames_in_window_reg <= '0;
            sleep_budget_reg     <= '0;
        end
        else if (step)
        begin
            frame_accum_reg      <= frame_accum_next;
            frame_mark_reg       <= frame_mark_next;
            window_accum_reg     <= window_accum_next;
            window_mark_reg      <= window_mark_next;
            frames_in_window_reg <= frames_in_window_next;
            sleep_budget_reg     <= sleep_budget_next;
        end
    end

    `FRL_ASSERT_IMPLY(a_run_on_poll, clk, rst_n, step && result.run_frame, item.command == CMD_POLL && !result.sleep_request && !result.stats_valid, "A frame ran on a non-poll word or with sleep or stats.")
    `FRL_ASSERT_IMPLY(a_sleep_has_budget, clk, rst_n, step && result.sleep_request, sleep_budget_reg != '0, "A sleep was requested with an empty budget.")
    `FRL_ASSERT_NEXT(a_budget_reload, clk, rst_n, step && result.run_frame, sleep_budget_reg == $past(cfg.sleep_budget_limit), "The sleep budget was not reloaded after a frame.")
    `FRL_ASSERT_NEXT(a_window_reset, clk, rst_n, step && result.stats_valid, frames_in_window_reg == '0 && window_mark_reg == window_accum_reg, "The window did not restart after it closed.")

endmodule

`default_nettype wire

// ===== sv/frame_rate_limiter_core.sv =====
// Frame rate limiter core.
// Input channel (in_valid, in_stall, in_word) carries one word per timing event:
// a poll or a work-done command with the counter ticks elapsed since the last one.
// Output channel (out_valid, out_stall, out_word) returns exactly one result word
// per input word, in order: frame decision, sleep request and window statistics.
// A word moves on a rising edge where valid is high and stall is low.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) writes
// register 0 frame period, 1 sleep margin, 2 window length, 3 sleep budget limit;
// other indexes are ignored. cfg_ready is always high. Write only while idle.
// The word waits in the input register while the timing engine works on it;
// the result register loads the result at the edge that takes the word, where
// the accumulators update too. Throughput is one word per cycle while the
// receiver does not stall; the next word depends on state left by the previous
// one, which is closed within that one engine pass.
// When the receiver stalls, the result register holds its word, the input
// register fills, and then in_stall rises until the output drains.
// Reset clears all accumulators, marks, counters, the budget, the configuration and the valid flags.
`default_nettype none

module frame_rate_limiter_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire frl_pkg::in_word_t   in_word,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output frl_pkg::out_word_t      out_word,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [frl_pkg::CfgIdxWidth-1:0] cfg_index,
    input  wire logic [frl_pkg::CfgDatWidth-1:0] cfg_data
);
    import frl_pkg::*;

    frl_cfg_t  cfg_reg;
    logic      held_valid;
    in_word_t  held_word;
    logic      take;
    out_word_t result;
    logic      out_valid_reg;
    logic      out_valid_next;
    out_word_t out_word_reg;

    assign cfg_ready = 1'b1;
    assign take      = held_valid && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    frl_input_stage u_input (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .take       (take),
        .held_valid (held_valid),
        .held_word  (held_word)
    );

    frl_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (take),
        .item   (held_word),
        .cfg    (cfg_reg),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_FRAME_PERIOD: cfg_reg.frame_period_ticks <= cfg_data;
                REG_SLEEP_MARGIN: cfg_reg.sleep_margin_ticks <= cfg_data;
                REG_WINDOW:       cfg_reg.window_ticks       <= cfg_data;
                REG_BUDGET_LIMIT: cfg_reg.sleep_budget_limit <= cfg_data[BudgetWidth-1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_word_reg <= result;
        end
    end

endmodule

`default_nettype wire
